[rtl/dwq_pkg.sv]
// ----------------------------------------------------------------------------
// dwq_pkg: shared types and constants for the delay wakeup queue.
// Defines the operation codes, slot count and reply kinds.
// ----------------------------------------------------------------------------
package dwq_pkg;

  localparam int unsigned MaxWaiters = 32;
  localparam int unsigned SlotW      = $clog2(MaxWaiters);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DELAY = 2'd1,
    OP_UNTIL = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_TIME    = 1'b1;

endpackage

[rtl/delay_wakeup_queue.sv]
// ----------------------------------------------------------------------------
// delay_wakeup_queue: tick counter with a time-ordered queue of sleeping tasks.
// A shared compare unit scans the slot memory one entry a cycle.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// request   in         req_valid_i, req_stall_o, operation_i, task_id_i,
//                      tick_amount_i
// reply     out        rsp_valid_o, rsp_stall_i, reply_kind_o, released_task_o,
//                      current_time_o, last_of_run_o
//
// Delays give no reply; due absolute delays and queries give one reply each.
// A tick with nothing due gives no reply; one that releases n tasks
// does one slot scan per release.
// Reset clears the time and all valid bits at once.
// A stalled reply holds the block until it is taken.
module delay_wakeup_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  task_id_i,
  input  logic [31:0] tick_amount_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic        reply_kind_o,
  output logic [7:0]  released_task_o,
  output logic [31:0] current_time_o,
  output logic        last_of_run_o
);

  localparam int unsigned SW = dwq_pkg::SlotW;
  localparam int unsigned CntW = $clog2(dwq_pkg::MaxWaiters + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_LAST, ST_EMIT, ST_OUT
  } state_e;

  state_e state_q;
  logic [31:0] time_q;
  logic [dwq_pkg::MaxWaiters-1:0] valid_q;
  logic [31:0] key_mem [dwq_pkg::MaxWaiters];
  logic [7:0]  id_mem  [dwq_pkg::MaxWaiters];
  logic [31:0] rd_key_q;
  logic [7:0]  rd_id_q;
  logic        rd_vld_q;
  logic [SW-1:0] rd_slot_q;
  logic [CntW-1:0] scan_q;
  logic        best_ok_q;
  logic        more_q;
  logic [31:0] best_key_q;
  logic [7:0]  best_id_q;
  logic [SW-1:0] best_slot_q;
  logic [5:0]  rel_cnt_q;
  logic        out_kind_q, out_last_q;
  logic [7:0]  out_id_q;

  logic accept, taken, cand, better;
  logic [SW-1:0] wslot;

  assign accept  = req_valid_i && (state_q == ST_IDLE);
  assign req_stall_o = (state_q != ST_IDLE);
  assign taken   = (state_q == ST_OUT) && !rsp_stall_i;
  assign wslot   = task_id_i[SW-1:0];
  assign cand    = rd_vld_q && (rd_key_q <= time_q);
  assign better  = !best_ok_q || (rd_key_q < best_key_q) ||
                   ((rd_key_q == best_key_q) && (rd_id_q < best_id_q));

  always_ff @(posedge clk_i) begin
    rd_key_q  <= key_mem[scan_q[SW-1:0]];
    rd_id_q   <= id_mem[scan_q[SW-1:0]];
    rd_slot_q <= scan_q[SW-1:0];
    if (accept && ((dwq_pkg::op_e'(operation_i) == dwq_pkg::OP_DELAY) ||
        ((dwq_pkg::op_e'(operation_i) == dwq_pkg::OP_UNTIL) &&
         (tick_amount_i > time_q)))) begin
      key_mem[wslot] <= (dwq_pkg::op_e'(operation_i) == dwq_pkg::OP_DELAY) ?
                        time_q + tick_amount_i : tick_amount_i;
      id_mem[wslot]  <= task_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      time_q     <= '0;
      valid_q    <= '0;
      rd_vld_q   <= 1'b0;
      scan_q     <= '0;
      best_ok_q  <= 1'b0;
      more_q     <= 1'b0;
      best_key_q <= '0;
      best_id_q  <= '0;
      best_slot_q <= '0;
      rel_cnt_q  <= '0;
      out_kind_q <= 1'b0;
      out_last_q <= 1'b0;
      out_id_q   <= '0;
    end else begin
      rd_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            out_id_q   <= task_id_i;
            out_last_q <= 1'b1;
            out_kind_q <= dwq_pkg::KIND_RELEASE;
            case (dwq_pkg::op_e'(operation_i))
              dwq_pkg::OP_TICK: begin
                time_q    <= time_q + 32'd1;
                rel_cnt_q <= '0;
                scan_q    <= '0;
                best_ok_q <= 1'b0;
                more_q    <= 1'b0;
                state_q   <= ST_SCAN;
              end
              dwq_pkg::OP_DELAY: valid_q[wslot] <= 1'b1;
              dwq_pkg::OP_UNTIL: begin
                if (tick_amount_i <= time_q) state_q <= ST_OUT;
                else valid_q[wslot] <= 1'b1;
              end
              default: begin
                out_kind_q <= dwq_pkg::KIND_TIME;
                state_q    <= ST_OUT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          rd_vld_q <= valid_q[scan_q[SW-1:0]];
          if (scan_q == CntW'(dwq_pkg::MaxWaiters - 1)) state_q <= ST_LAST;
          else scan_q <= scan_q + 1'b1;
          if (cand) begin
            if (best_ok_q) more_q <= 1'b1;
            if (better) begin
              best_ok_q <= 1'b1; best_key_q <= rd_key_q;
              best_id_q <= rd_id_q; best_slot_q <= rd_slot_q;
            end
          end
        end
        ST_LAST: begin
          if (cand) begin
            if (best_ok_q) more_q <= 1'b1;
            if (better) begin
              best_ok_q <= 1'b1; best_key_q <= rd_key_q;
              best_id_q <= rd_id_q; best_slot_q <= rd_slot_q;
            end
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (best_ok_q) begin
            // A second due task found by the scan means this release does not end the run.
            valid_q[best_slot_q] <= 1'b0;
            out_id_q   <= best_id_q;
            rel_cnt_q  <= rel_cnt_q + 6'd1;
            out_last_q <= !more_q || (rel_cnt_q == 6'd31);
            state_q    <= ST_OUT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (taken) begin
            if (out_last_q) begin
              state_q <= ST_IDLE;
            end else begin
              scan_q    <= '0;
              best_ok_q <= 1'b0;
              more_q    <= 1'b0;
              state_q   <= ST_SCAN;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_valid_o     = (state_q == ST_OUT);
  assign reply_kind_o    = out_kind_q;
  assign released_task_o = out_id_q;
  assign current_time_o  = time_q;
  assign last_of_run_o   = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o)
    else $error("reply dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> req_stall_o)
    else $error("request taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_cnt_q <= 6'd32)
    else $error("release count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(time_q))
    else $error("time moved during scan");

endmodule

[tb/delay_wakeup_queue_tb.sv]
// ----------------------------------------------------------------------------
// delay_wakeup_queue_tb: self-checking testbench for the delay wakeup queue.
// A behavioral copy of the sleep queue predicts every reply. Directed cases
// come first, then random traffic under three idling mixes on both channels.
// ----------------------------------------------------------------------------
module delay_wakeup_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 3 * dwq_pkg::MaxWaiters + 10;

  typedef struct packed {
    logic        kind;
    logic [7:0]  id;
    logic [31:0] now;
    logic        last;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_stall_o;
  logic [1:0]  operation_i = dwq_pkg::OP_TICK;
  logic [7:0]  task_id_i = '0;
  logic [31:0] tick_amount_i = '0;
  logic        rsp_valid_o;
  logic        rsp_stall_i = 1'b0;
  logic        reply_kind_o;
  logic [7:0]  released_task_o;
  logic [31:0] current_time_o;
  logic        last_of_run_o;

  logic [31:0] ticks_now = '0;
  logic [31:0] sleep_key [dwq_pkg::MaxWaiters];
  logic [7:0]  sleep_id [dwq_pkg::MaxWaiters];
  logic        sleeping [dwq_pkg::MaxWaiters];
  reply_t      pending_replies[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned replies_seen = 0;

  delay_wakeup_queue u_top (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .operation_i, .task_id_i,
    .tick_amount_i, .rsp_valid_o, .rsp_stall_i, .reply_kind_o,
    .released_task_o, .current_time_o, .last_of_run_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void push_reply(logic kind, logic [7:0] id, logic last);
    pending_replies.push_back('{kind: kind, id: id, now: ticks_now, last: last});
  endfunction

  function automatic void queue_sleeper(logic [7:0] id, logic [31:0] key);
    int unsigned s;
    s = id % dwq_pkg::MaxWaiters;
    sleeping[s] = 1'b1;
    sleep_key[s] = key;
    sleep_id[s] = id;
  endfunction

  function automatic void predict_request(dwq_pkg::op_e op, logic [7:0] id,
                                          logic [31:0] amt);
    int best;
    int n;
    case (op)
      dwq_pkg::OP_TICK: begin
        ticks_now = ticks_now + 32'd1;
        n = 0;
        do begin
          best = -1;
          for (int s = 0; s < dwq_pkg::MaxWaiters; s++) begin
            if (sleeping[s] && sleep_key[s] <= ticks_now) begin
              if (best < 0 || sleep_key[s] < sleep_key[best] ||
                  (sleep_key[s] == sleep_key[best] && sleep_id[s] < sleep_id[best])) begin
                best = s;
              end
            end
          end
          if (best >= 0) begin
            sleeping[best] = 1'b0;
            push_reply(dwq_pkg::KIND_RELEASE, sleep_id[best], 1'b0);
            n++;
          end
        end while (best >= 0 && n < 32);
        if (n > 0) begin
          pending_replies[$].last = 1'b1;
        end
      end
      dwq_pkg::OP_DELAY: queue_sleeper(id, ticks_now + amt);
      dwq_pkg::OP_UNTIL: begin
        if (amt <= ticks_now) begin
          push_reply(dwq_pkg::KIND_RELEASE, id, 1'b1);
        end else begin
          queue_sleeper(id, amt);
        end
      end
      default: push_reply(dwq_pkg::KIND_TIME, id, 1'b1);
    endcase
  endfunction

  task automatic send_request(dwq_pkg::op_e op, logic [7:0] id, logic [31:0] amt);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 8) begin
      gap++;
    end
    @(negedge clk_i);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    operation_i <= op;
    task_id_i <= id;
    tick_amount_i <= amt;
    do @(posedge clk_i); while (req_stall_o);
    predict_request(op, id, amt);
    requests_sent++;
  endtask

  task automatic wait_all_replies();
    @(negedge clk_i);
    req_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall_i <= 1'b1;
    end else begin
      rsp_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected reply: kind %0d task %0d time %0d last %0d",
                   reply_kind_o, released_task_o, current_time_o, last_of_run_o);
        end
      end else begin
        want = pending_replies.pop_front();
        if (want.kind !== reply_kind_o || want.id !== released_task_o ||
            want.now !== current_time_o || want.last !== last_of_run_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Reply mismatch: expected kind %0d task %0d time %0d last %0d",
                     want.kind, want.id, want.now, want.last);
            $display("                actual   kind %0d task %0d time %0d last %0d",
                     reply_kind_o, released_task_o, current_time_o, last_of_run_o);
          end
        end
      end
    end
  end

  task automatic test_corner_amounts();
    send_request(dwq_pkg::OP_QUERY, 8'd0, 32'hFFFF_FFFF);
    send_request(dwq_pkg::OP_UNTIL, 8'd255, 32'd0);
    send_request(dwq_pkg::OP_UNTIL, 8'd1, 32'hFFFF_FFFF);
    send_request(dwq_pkg::OP_DELAY, 8'd2, 32'd0);
    send_request(dwq_pkg::OP_DELAY, 8'd3, 32'hFFFF_FFFF);
    send_request(dwq_pkg::OP_TICK, 8'hAA, 32'h5555_5555);
    send_request(dwq_pkg::OP_TICK, 8'd0, 32'd0);
    send_request(dwq_pkg::OP_QUERY, 8'd255, 32'd0);
  endtask

  task automatic test_busy_slot_and_ties();
    send_request(dwq_pkg::OP_DELAY, 8'd5, 32'd3);
    send_request(dwq_pkg::OP_DELAY, 8'd37, 32'd1);
    send_request(dwq_pkg::OP_DELAY, 8'd9, 32'd1);
    send_request(dwq_pkg::OP_UNTIL, 8'd8, ticks_now + 32'd1);
    send_request(dwq_pkg::OP_TICK, 8'd0, 32'd0);
    send_request(dwq_pkg::OP_TICK, 8'd0, 32'd0);
    send_request(dwq_pkg::OP_TICK, 8'd0, 32'd0);
  endtask

  task automatic test_full_burst_under_backpressure();
    for (int i = 0; i < dwq_pkg::MaxWaiters; i++) begin
      send_request(dwq_pkg::OP_DELAY, 8'(i + 64), 32'd1);
    end
    send_request(dwq_pkg::OP_DELAY, 8'd100, 32'd2);
    wait_all_replies();
    hold_left = 400;
    send_request(dwq_pkg::OP_TICK, 8'd0, 32'd0);
    send_request(dwq_pkg::OP_QUERY, 8'd7, 32'd0);
    send_request(dwq_pkg::OP_TICK, 8'd0, 32'd0);
    send_request(dwq_pkg::OP_QUERY, 8'd8, 32'd0);
    wait_all_replies();
  endtask

  task automatic test_random_traffic(int unsigned count);
    int unsigned pick;
    logic [31:0] amt;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      amt = $urandom();
      if (pick < 35) begin
        send_request(dwq_pkg::OP_TICK, 8'($urandom()), amt);
      end else if (pick < 65) begin
        if ($urandom_range(0, 19) != 0) amt = $urandom_range(0, 6);
        send_request(dwq_pkg::OP_DELAY, 8'($urandom()), amt);
      end else if (pick < 82) begin
        if ($urandom_range(0, 9) != 0) amt = ticks_now + $urandom_range(0, 6) - 32'd2;
        send_request(dwq_pkg::OP_UNTIL, 8'($urandom()), amt);
      end else begin
        send_request(dwq_pkg::OP_QUERY, 8'($urandom()), amt);
      end
    end
  endtask

  initial begin
    for (int s = 0; s < dwq_pkg::MaxWaiters; s++) sleeping[s] = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_amounts();
    test_busy_slot_and_ties();
    test_full_burst_under_backpressure();
    send_idle_pct = 22;
    recv_idle_pct = 61;
    test_random_traffic(45);
    send_idle_pct = 61;
    recv_idle_pct = 22;
    test_random_traffic(45);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(45);
    wait_all_replies();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d replies: ticks, delays, absolute delays,",
             requests_sent, replies_seen);
    $display("queries, slot reuse, full release bursts and back-pressure; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
